### rtl/hrcm_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// hrcm_pkg
// Shared widths, basis constants and register indexes of the hue rotation unit.
// -----------------------------------------------------------------------------
package hrcm_pkg;

	localparam int ChanW  = 8;
	localparam int TermW  = 16;
	localparam int CfgIdxW = 2;

	// orthonormal basis constants, Q1.14
	localparam logic signed [15:0] K_HALF     = 16'sd11585;
	localparam logic signed [15:0] K_SIXTH    = 16'sd6689;
	localparam logic signed [15:0] K_TWOTHIRD = 16'sd13377;
	localparam logic signed [15:0] K_THIRD    = 16'sd9459;

	localparam int AccW = 56;
	localparam int FracOut = 40;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_COS_TERM = 2'd0,
		CFG_SIN_TERM = 2'd1
	} cfg_idx_t;

endpackage
`default_nettype wire

### rtl/hrcm_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// hrcm_in_if / hrcm_out_if
// Valid/ready channels carrying one ARGB color and its last-entry marker.
// -----------------------------------------------------------------------------
interface hrcm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;
	logic       final_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, final_in,
		input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, final_in,
		output ready);
endinterface

interface hrcm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	logic       final_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, final_out,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, final_out,
		output ready);
endinterface
`default_nettype wire

### rtl/hue_rotate_color_matrix_unit.sv
`default_nettype none
// -----------------------------------------------------------------------------
// hue_rotate_color_matrix_unit
// Rotates the chroma of an ARGB color about the gray axis and scales it.
// -----------------------------------------------------------------------------
// Usage:
//   in_ch carries one color per item (red, green, blue, alpha, last-entry
//   marker); out_ch returns the rotated color, rounded and saturated to
//   0..255, with alpha and the marker copied through. One result per item.
//   cfg_we/cfg_index/cfg_data write cos_term (index 0) and sin_term (index 1),
//   both signed Q4.12; other indexes are ignored. Write them only while the
//   pipeline is empty.
// Timing:
//   Five register stages: basis projection, chroma products, rotation sums,
//   back projection products, accumulate with round and saturate. An item
//   accepted passes the five stages in that order and out_ch.valid comes from
//   the last; one item per cycle sustained while out_ch.ready stays high.
// Stall:
//   Each stage holds while it is full and the stage after it holds, so bubbles
//   close up; in_ch.ready is low only with all five full and out_ch.ready low.
// Reset:
//   arst_n empties the pipeline and loads cos_term = 1.0, sin_term = 0.
// -----------------------------------------------------------------------------
module hue_rotate_color_matrix_unit
	import hrcm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	hrcm_in_if.sink                 in_ch,
	hrcm_out_if.source              out_ch,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [TermW-1:0]   cfg_data
);

	logic signed [TermW-1:0] cos_q, sin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= 16'sd4096;
			sin_q <= 16'sd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COS_TERM: cos_q <= $signed(cfg_data);
				CFG_SIN_TERM: sin_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage enables: advance when empty or when the next stage advances
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = !v_s5 || out_ch.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// pass-through fields
	logic [7:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5;
	logic       final_s1, final_s2, final_s3, final_s4, final_s5;

	always_ff @(posedge clk) begin
		if (en1) begin
			alpha_s1 <= in_ch.alpha_in;
			final_s1 <= in_ch.final_in;
		end
		if (en2) begin
			alpha_s2 <= alpha_s1;
			final_s2 <= final_s1;
		end
		if (en3) begin
			alpha_s3 <= alpha_s2;
			final_s3 <= final_s2;
		end
		if (en4) begin
			alpha_s4 <= alpha_s3;
			final_s4 <= final_s3;
		end
		if (en5) begin
			alpha_s5 <= alpha_s4;
			final_s5 <= final_s4;
		end
	end

	// stage 1: project onto chroma axes X, Y and gray axis Z (Q14)
	logic signed [9:0]  r_e, g_e, b_e, diff_br, sum_rb;
	logic signed [10:0] sum_rgb;
	logic signed [23:0] x_s1, y_s1, z_s1;

	always_comb begin
		r_e     = $signed({2'b00, in_ch.red_in});
		g_e     = $signed({2'b00, in_ch.green_in});
		b_e     = $signed({2'b00, in_ch.blue_in});
		diff_br = b_e - r_e;
		sum_rb  = r_e + b_e;
		sum_rgb = 11'(r_e) + 11'(g_e) + 11'(b_e);
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1 <= 24'(K_HALF * diff_br);
			y_s1 <= 24'(K_TWOTHIRD * g_e) - 24'(K_SIXTH * sum_rb);
			z_s1 <= 24'(K_THIRD * sum_rgb);
		end
	end

	// stage 2: chroma products with the rotation terms
	logic signed [39:0] xc_s2, ys_s2, yc_s2, xs_s2;
	logic signed [23:0] z_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			xc_s2 <= 40'(x_s1 * cos_q);
			ys_s2 <= 40'(y_s1 * sin_q);
			yc_s2 <= 40'(y_s1 * cos_q);
			xs_s2 <= 40'(x_s1 * sin_q);
			z_s2  <= z_s1;
		end
	end

	// stage 3: rotated chroma (Q26) and gray term
	logic signed [40:0] x2_s3, y2_s3;
	logic signed [39:0] zk_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			x2_s3 <= 41'(xc_s2) - 41'(ys_s2);
			y2_s3 <= 41'(yc_s2) + 41'(xs_s2);
			zk_s3 <= 40'(K_THIRD * z_s2);
		end
	end

	// stage 4: back projection products, aligned to Q40
	logic signed [AccW-1:0] tx_s4, ty6_s4, ty3_s4, zt_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			tx_s4  <= AccW'(K_HALF * x2_s3);
			ty6_s4 <= AccW'(K_SIXTH * y2_s3);
			ty3_s4 <= AccW'(K_TWOTHIRD * y2_s3);
			zt_s4  <= AccW'(zk_s3) <<< 12;
		end
	end

	// stage 5: accumulate, round half up, saturate
	localparam logic signed [AccW-1:0] Half = AccW'(1) <<< (FracOut - 1);

	logic signed [AccW-1:0] acc_r, acc_g, acc_b;

	function automatic logic [7:0] round_sat(input logic signed [AccW-1:0] t);
		logic [7:0] res;
		if (t[AccW-1]) begin
			res = 8'd0;
		end else if (|t[AccW-2:FracOut+8]) begin
			res = 8'd255;
		end else begin
			res = t[FracOut+7:FracOut];
		end
		return res;
	endfunction

	always_comb begin
		acc_r = zt_s4 - tx_s4 - ty6_s4 + Half;
		acc_g = zt_s4 + ty3_s4 + Half;
		acc_b = zt_s4 + tx_s4 - ty6_s4 + Half;
	end

	logic [7:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5   <= round_sat(acc_r);
			green_s5 <= round_sat(acc_g);
			blue_s5  <= round_sat(acc_b);
		end
	end

	assign out_ch.valid     = v_s5;
	assign out_ch.red_out   = red_s5;
	assign out_ch.green_out = green_s5;
	assign out_ch.blue_out  = blue_s5;
	assign out_ch.alpha_out = alpha_s5;
	assign out_ch.final_out = final_s5;

endmodule
`default_nettype wire

### rtl/hrcm_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// hrcm_checker
// Port-level checks of the hue rotation unit, bound to the top level.
// -----------------------------------------------------------------------------
module hrcm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] red_out,
	input wire logic [7:0] alpha_out,
	input wire logic       final_out
);

	logic [2:0] occ_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 3'd0;
		end else begin
			occ_q <= occ_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red_out)
			&& $stable(alpha_out) && $stable(final_out))
		else $error("stalled result changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != 3'd0)
		else $error("result without a pending item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 3'd5)
		else $error("more items inside than stages");

	a_ready_flows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

endmodule

bind hue_rotate_color_matrix_unit hrcm_checker u_hrcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.red_out   (out_ch.red_out),
	.alpha_out (out_ch.alpha_out),
	.final_out (out_ch.final_out)
);
`default_nettype wire
